// File: src/sas_pkg.sv
package sas_pkg;

  localparam int FrameWords = 256;
  localparam int NumAnims   = 16;
  localparam int MaxFrames  = 64;
  localparam int FwAddrW    = $clog2(FrameWords);
  localparam int AnimIdW    = $clog2(NumAnims);

  typedef enum logic [2:0] {
    ACT_TICK     = 3'd0,
    ACT_PLAY     = 3'd1,
    ACT_PLAY_OVR = 3'd2,
    ACT_STOP     = 3'd3,
    ACT_WR_FRAME = 3'd4,
    ACT_WR_DESC  = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_TILE,
    ST_DIV
  } state_e;

  typedef logic [4:0] cols_t;

  typedef struct packed {
    logic [2:0] action;
    logic [3:0] anim_id;
    logic       restart;
    logic [7:0] rate_override;
    logic       loop_override;
    logic [7:0] mem_addr;
    logic [7:0] tile_value;
    logic [6:0] desc_length;
    logic [7:0] desc_rate;
    logic       desc_loop;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tile_number;
    logic [3:0] tile_column;
    logic [7:0] tile_row;
    logic [5:0] frame_position;
    logic       anim_finished;
    logic       anim_active;
    logic [7:0] held_tile;
  } out_item_t;

  typedef struct packed {
    logic [7:0] base;
    logic [6:0] length;
    logic [7:0] rate;
    logic       loop;
  } desc_t;

  typedef struct packed {
    logic               we;
    logic [FwAddrW-1:0] waddr;
    logic [7:0]         wdata;
    logic               re;
    logic [FwAddrW-1:0] raddr;
  } frame_req_t;

  typedef struct packed {
    logic               we;
    logic [AnimIdW-1:0] waddr;
    desc_t              wdata;
    logic               re;
    logic [AnimIdW-1:0] raddr;
  } table_req_t;

  // ceil(2^16 / c); exact floor(n / c) for n < 256, c <= 16
  function automatic logic [16:0] col_recip(cols_t c);
    logic [16:0] r;
    case (c)
      5'd1:    r = 17'd65536;
      5'd2:    r = 17'd32768;
      5'd3:    r = 17'd21846;
      5'd4:    r = 17'd16384;
      5'd5:    r = 17'd13108;
      5'd6:    r = 17'd10923;
      5'd7:    r = 17'd9363;
      5'd8:    r = 17'd8192;
      5'd9:    r = 17'd7282;
      5'd10:   r = 17'd6554;
      5'd11:   r = 17'd5958;
      5'd12:   r = 17'd5462;
      5'd13:   r = 17'd5042;
      5'd14:   r = 17'd4682;
      5'd15:   r = 17'd4370;
      default: r = 17'd4096;
    endcase
    return r;
  endfunction

endpackage

// File: src/sas_stream_if.sv
interface sas_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: src/sas_frame_mem.sv
module sas_frame_mem import sas_pkg::*; (
  input  logic       clk_i,
  input  frame_req_t req_i,
  output logic [7:0] rdata_o
);

  logic [7:0] mem_q [FrameWords];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      // write-first on same-address collision
      if (req_i.we && (req_i.waddr == req_i.raddr)) begin
        rdata_q <= req_i.wdata;
      end else begin
        rdata_q <= mem_q[req_i.raddr];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/sas_anim_table.sv
module sas_anim_table import sas_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  table_req_t req_i,
  output desc_t      rdata_o
);

  desc_t               mem_q [NumAnims];
  logic [NumAnims-1:0] valid_q;
  desc_t               rd_q;
  logic                rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_q <= mem_q[req_i.raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        valid_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        rd_valid_q <= valid_q[req_i.raddr];
      end
    end
  end

  // unwritten entries read as absent
  assign rdata_o = rd_valid_q ? rd_q : '0;

endmodule

// File: src/sas_tile_div.sv
module sas_tile_div import sas_pkg::*; (
  input  logic       clk_i,
  input  logic       load_i,
  input  logic [7:0] tile_i,
  input  cols_t      cols_i,
  output logic [7:0] tile_o,
  output logic [3:0] column_o,
  output logic [7:0] row_o
);

  logic [7:0]  tile_q;
  logic [24:0] prod_q;
  logic [12:0] back;
  logic [7:0]  rem;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      tile_q <= tile_i;
      prod_q <= 25'(tile_i) * 25'(col_recip(cols_i));
    end
  end

  assign row_o    = prod_q[23:16];
  assign back     = 13'(row_o) * 13'(cols_i);
  assign rem      = tile_q - back[7:0];
  assign column_o = rem[3:0];
  assign tile_o   = tile_q;

endmodule

// File: src/sprite_animation_sequencer.sv
// Channel  Dir  Payload      Transfer when
// in_i     in   in_item_t    in_i.valid  && in_i.ready
// out_o    out  out_item_t   out_o.valid && out_o.ready
// cfg_i    in   cols_t       cfg_i.valid && cfg_i.ready (always ready)
//
// Steps per item: accept with descriptor read, update with frame
// memory access, tile read plus reciprocal multiply, then remainder and
// result load. One item in flight; the registered descriptor table read
// and the registered frame memory read set the step count.
// Reset clears the descriptor table valid bits at once; no sweep.
// A stalled output holds the final step until the result register frees.
module sprite_animation_sequencer import sas_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  sas_stream_if.sink   in_i,
  sas_stream_if.source out_o,
  sas_stream_if.sink   cfg_i
);

  state_e     state_q, state_d;
  in_item_t   item_q;
  cols_t      cols_q;
  logic [3:0] cur_q, cur_d;
  logic       active_q, active_d;
  logic [5:0] frame_q, frame_d;
  logic [7:0] step_q, step_d;
  logic       done_q, done_d;
  logic [7:0] rate_q, rate_d;
  logic       loop_q, loop_d;
  logic [7:0] base_q, base_d;
  logic       latch_q, latch_d;
  logic [7:0] held_q;
  logic       out_valid_q;
  out_item_t  out_q;

  logic       accept, div_load, out_load;
  table_req_t tbl_req;
  desc_t      desc;
  frame_req_t frm_req;
  logic [7:0] frm_rdata;
  logic [7:0] div_tile, div_row;
  logic [3:0] div_col;
  logic [6:0] frame_inc, last, sat_len;

  sas_anim_table u_table (
    .clk_i,
    .rst_ni,
    .req_i   (tbl_req),
    .rdata_o (desc)
  );

  sas_frame_mem u_frames (
    .clk_i,
    .req_i   (frm_req),
    .rdata_o (frm_rdata)
  );

  sas_tile_div u_div (
    .clk_i,
    .load_i   (div_load),
    .tile_i   (active_q ? frm_rdata : 8'd0),
    .cols_i   (cols_q),
    .tile_o   (div_tile),
    .column_o (div_col),
    .row_o    (div_row)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_i.valid) state_d = ST_EXEC;
      ST_EXEC: state_d = ST_TILE;
      ST_TILE: state_d = ST_DIV;
      ST_DIV:  if (!out_valid_q || out_o.ready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready  = (state_q == ST_IDLE);
    cfg_i.ready = 1'b1;
    accept      = in_i.valid && (state_q == ST_IDLE);
    div_load    = (state_q == ST_TILE);
    out_load    = (state_q == ST_DIV) && (!out_valid_q || out_o.ready);
  end

  assign sat_len   = (item_q.desc_length > 7'(MaxFrames)) ? 7'(MaxFrames)
                                                           : item_q.desc_length;
  assign frame_inc = {1'b0, frame_q} + 7'd1;
  assign last      = (desc.length != 7'd0) ? desc.length - 7'd1 : 7'd0;

  always_comb begin
    cur_d    = cur_q;
    active_d = active_q;
    frame_d  = frame_q;
    step_d   = step_q;
    done_d   = done_q;
    rate_d   = rate_q;
    loop_d   = loop_q;
    base_d   = base_q;
    latch_d  = 1'b0;
    if (state_q == ST_EXEC) begin
      case (item_q.action) inside
        ACT_TICK: begin
          if (active_q && !done_q) begin
            if (step_q >= rate_q) begin
              step_d = 8'd1;
              if (frame_inc >= desc.length) begin
                if (!loop_q) begin
                  done_d  = 1'b1;
                  frame_d = last[5:0];
                  latch_d = 1'b1;
                end else begin
                  frame_d = '0;
                end
              end else begin
                frame_d = frame_inc[5:0];
              end
            end else begin
              step_d = step_q + 8'd1;
            end
          end
        end
        ACT_PLAY, ACT_PLAY_OVR: begin
          if (desc.length != 7'd0) begin
            if (!(active_q && cur_q == item_q.anim_id)) begin
              cur_d    = item_q.anim_id;
              active_d = 1'b1;
              rate_d   = desc.rate;
              loop_d   = desc.loop;
              base_d   = desc.base;
              frame_d  = '0;
              step_d   = '0;
              done_d   = 1'b0;
            end else if (item_q.restart) begin
              frame_d = '0;
              step_d  = '0;
              done_d  = 1'b0;
            end
            if (item_q.action == ACT_PLAY_OVR) begin
              rate_d = item_q.rate_override;
              loop_d = item_q.loop_override;
            end
          end
        end
        ACT_STOP: latch_d = active_q;
        ACT_WR_DESC: begin
          if (item_q.anim_id == cur_q) begin
            base_d = item_q.mem_addr;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    tbl_req.re    = accept;
    if (in_i.payload.action == ACT_PLAY || in_i.payload.action == ACT_PLAY_OVR) begin
      tbl_req.raddr = in_i.payload.anim_id;
    end else begin
      tbl_req.raddr = cur_q;
    end
    tbl_req.we    = (state_q == ST_EXEC) && (item_q.action == ACT_WR_DESC);
    tbl_req.waddr = item_q.anim_id;
    tbl_req.wdata = '{base: item_q.mem_addr, length: sat_len,
                      rate: item_q.desc_rate, loop: item_q.desc_loop};
    frm_req.we    = (state_q == ST_EXEC) && (item_q.action == ACT_WR_FRAME);
    frm_req.waddr = item_q.mem_addr;
    frm_req.wdata = item_q.tile_value;
    frm_req.re    = (state_q == ST_EXEC);
    frm_req.raddr = base_d + {2'b00, frame_d};
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_i.payload;
    end
    if (out_load) begin
      out_q <= '{tile_number: div_tile, tile_column: div_col, tile_row: div_row,
                 frame_position: frame_q, anim_finished: done_q,
                 anim_active: active_q, held_tile: held_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cols_q      <= 5'd1;
      cur_q       <= '0;
      active_q    <= 1'b0;
      frame_q     <= '0;
      step_q      <= 8'd1;
      done_q      <= 1'b0;
      rate_q      <= '0;
      loop_q      <= 1'b0;
      base_q      <= '0;
      latch_q     <= 1'b0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cur_q    <= cur_d;
      active_q <= active_d;
      frame_q  <= frame_d;
      step_q   <= step_d;
      done_q   <= done_d;
      rate_q   <= rate_d;
      loop_q   <= loop_d;
      base_q   <= base_d;
      if (state_q == ST_EXEC) begin
        latch_q <= latch_d;
      end
      if (state_q == ST_TILE && latch_q) begin
        held_q <= frm_rdata;
      end
      if (cfg_i.valid) begin
        if (cfg_i.payload == 5'd0) begin
          cols_q <= 5'd1;
        end else if (cfg_i.payload > 5'd16) begin
          cols_q <= 5'd16;
        end else begin
          cols_q <= cfg_i.payload;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

endmodule
